### rtl/spw_pkg.sv
// Shared types, codes and helper functions of the sample poll watchdog.
// Used by the interfaces, the scheduling engine and the top level.
package spw_pkg;

	// Width of a time value; interval and limit values are MsBits wide
	localparam int TimeBits = 48;
	localparam int MsBits   = 20;
	localparam int TagBits  = 8;
	localparam int ValBits  = 32;
	localparam int CfgIdxBits = 2;

	typedef logic [TimeBits-1:0] time_t;
	typedef logic [MsBits-1:0]   ms_t;

	// Event codes carried in the cmd field
	typedef enum logic [2:0] {
		CMD_TICK          = 3'd0,
		CMD_REPLY_OK      = 3'd1,
		CMD_REPLY_FAIL    = 3'd2,
		CMD_START         = 3'd3,
		CMD_STOP          = 3'd4,
		CMD_SET_INTERVAL  = 3'd5,
		CMD_SET_HOLD      = 3'd6,
		CMD_SELECT_SOURCE = 3'd7
	} cmd_t;

	// Configuration register indexes
	localparam logic [CfgIdxBits-1:0] CFG_TIMEOUT_LIMIT    = 2'd0;
	localparam logic [CfgIdxBits-1:0] CFG_INTERVAL_FLOOR   = 2'd1;
	localparam logic [CfgIdxBits-1:0] CFG_INTERVAL_CEILING = 2'd2;

	// Register reset values
	localparam ms_t TIMEOUT_LIMIT_RST    = 20'd3000;
	localparam ms_t INTERVAL_FLOOR_RST   = 20'd10;
	localparam ms_t INTERVAL_CEILING_RST = 20'd600000;

	typedef struct packed {
		cmd_t                      cmd;
		time_t                     now_time;
		logic                      source_open;
		logic [TagBits-1:0]        source_tag;
		logic signed [ValBits-1:0] reading_value;
		ms_t                       interval_request;
		logic                      hold_value;
	} evt_t;

	typedef struct packed {
		logic                      request_reading;
		logic                      sample_valid;
		logic                      sample_ok;
		time_t                     sample_time;
		logic signed [ValBits-1:0] sample_value;
		logic                      timeout_event;
		logic                      failure_event;
		logic                      start_rejected;
		logic                      buffer_cleared;
	} res_t;

	typedef struct packed {
		ms_t timeout_limit;
		ms_t interval_floor;
		ms_t interval_ceiling;
	} cfg_t;

	// Time plus interval, saturating at the largest time
	function automatic time_t sat_add(time_t a, ms_t b);
		logic [TimeBits:0] s;
		s = {1'b0, a} + {{(TimeBits + 1 - MsBits){1'b0}}, b};
		return s[TimeBits] ? {TimeBits{1'b1}} : s[TimeBits-1:0];
	endfunction

	// Clamp to floor first, then ceiling (ceiling wins when floor is above it)
	function automatic ms_t clamp_interval(ms_t ms, ms_t lo, ms_t hi);
		ms_t v;
		v = (ms < lo) ? lo : ms;
		return (v > hi) ? hi : v;
	endfunction

endpackage

### rtl/spw_if.sv
// Handshake channels of the sample poll watchdog: event in, result out,
// and the configuration write channel. Depends on spw_pkg.
interface spw_evt_if;
	logic                               valid;
	logic                               ready;
	spw_pkg::cmd_t                      cmd;
	spw_pkg::time_t                     now_time;
	logic                               source_open;
	logic [spw_pkg::TagBits-1:0]        source_tag;
	logic signed [spw_pkg::ValBits-1:0] reading_value;
	spw_pkg::ms_t                       interval_request;
	logic                               hold_value;

	modport source (output valid, cmd, now_time, source_open, source_tag,
		reading_value, interval_request, hold_value, input ready);
	modport sink (input valid, cmd, now_time, source_open, source_tag,
		reading_value, interval_request, hold_value, output ready);
endinterface

interface spw_res_if;
	logic                               valid;
	logic                               ready;
	logic                               request_reading;
	logic                               sample_valid;
	logic                               sample_ok;
	spw_pkg::time_t                     sample_time;
	logic signed [spw_pkg::ValBits-1:0] sample_value;
	logic                               timeout_event;
	logic                               failure_event;
	logic                               start_rejected;
	logic                               buffer_cleared;

	modport source (output valid, request_reading, sample_valid, sample_ok,
		sample_time, sample_value, timeout_event, failure_event, start_rejected,
		buffer_cleared, input ready);
	modport sink (input valid, request_reading, sample_valid, sample_ok,
		sample_time, sample_value, timeout_event, failure_event, start_rejected,
		buffer_cleared, output ready);
endinterface

interface spw_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [spw_pkg::CfgIdxBits-1:0] index;
	spw_pkg::ms_t                   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/spw_engine.sv
// Scheduler state and per-event decision logic of the sample poll watchdog.
// Depends on spw_pkg; instantiated by sample_poll_watchdog.
module spw_engine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  spw_pkg::evt_t  item,
	input  spw_pkg::cfg_t  cfg,
	output spw_pkg::res_t  res
);

	spw_pkg::time_t time_now_q, time_sent_q, time_due_q;
	spw_pkg::time_t time_now_d, time_sent_d, time_due_d;
	spw_pkg::ms_t   interval_q, interval_d, clamped;
	logic running_q, pending_q, timed_out_q, hold_q;
	logic running_d, pending_d, timed_out_d, hold_d;
	logic [spw_pkg::TagBits-1:0] source_q, source_d;

	logic [spw_pkg::TimeBits:0] diff;
	spw_pkg::time_t             elapsed;
	logic                       expired;

	// Elapsed time since the request went out, zero when time went backwards
	assign diff    = {1'b0, item.now_time} - {1'b0, time_sent_q};
	assign elapsed = diff[spw_pkg::TimeBits] ? '0 : diff[spw_pkg::TimeBits-1:0];
	assign expired = elapsed >
		{{(spw_pkg::TimeBits - spw_pkg::MsBits){1'b0}}, cfg.timeout_limit};
	assign clamped = spw_pkg::clamp_interval(item.interval_request,
		cfg.interval_floor, cfg.interval_ceiling);

	// Decide the result and next state of one item
	always_comb begin
		time_now_d  = time_now_q;
		time_sent_d = time_sent_q;
		time_due_d  = time_due_q;
		interval_d  = interval_q;
		running_d   = running_q;
		pending_d   = pending_q;
		timed_out_d = timed_out_q;
		hold_d      = hold_q;
		source_d    = source_q;
		res         = '0;
		unique case (item.cmd)
			spw_pkg::CMD_TICK: begin
				time_now_d = item.now_time;
				if (running_q) begin
					if (pending_q) begin
						if (!timed_out_q && expired) begin
							timed_out_d       = 1'b1;
							res.sample_valid  = 1'b1;
							res.sample_time   = item.now_time;
							res.timeout_event = 1'b1;
							time_due_d = spw_pkg::sat_add(item.now_time, interval_q);
						end
					end else if (!hold_q && item.source_open &&
							item.now_time >= time_due_q) begin
						time_sent_d         = item.now_time;
						pending_d           = 1'b1;
						res.request_reading = 1'b1;
					end
				end
			end
			spw_pkg::CMD_REPLY_OK, spw_pkg::CMD_REPLY_FAIL: begin
				if (pending_q && item.source_tag == source_q) begin
					pending_d        = 1'b0;
					timed_out_d      = 1'b0;
					res.sample_valid = 1'b1;
					res.sample_time  = time_now_q;
					if (item.cmd == spw_pkg::CMD_REPLY_OK) begin
						res.sample_ok    = 1'b1;
						res.sample_value = item.reading_value;
					end else begin
						res.failure_event = 1'b1;
					end
					time_due_d = spw_pkg::sat_add(time_now_q, interval_q);
				end
			end
			spw_pkg::CMD_START: begin
				if (!item.source_open) begin
					res.start_rejected = 1'b1;
				end else begin
					interval_d  = clamped;
					running_d   = 1'b1;
					pending_d   = 1'b0;
					timed_out_d = 1'b0;
					time_due_d  = time_now_q;
				end
			end
			spw_pkg::CMD_STOP: begin
				running_d   = 1'b0;
				pending_d   = 1'b0;
				timed_out_d = 1'b0;
			end
			spw_pkg::CMD_SET_INTERVAL: begin
				if (clamped != interval_q) begin
					interval_d = clamped;
					if (running_q && !pending_q)
						time_due_d = spw_pkg::sat_add(time_now_q, clamped);
				end
			end
			spw_pkg::CMD_SET_HOLD: begin
				if (item.hold_value != hold_q) begin
					hold_d = item.hold_value;
					if (!item.hold_value)
						time_due_d = time_now_q;
				end
			end
			spw_pkg::CMD_SELECT_SOURCE: begin
				if (item.source_tag != source_q) begin
					source_d           = item.source_tag;
					pending_d          = 1'b0;
					timed_out_d        = 1'b0;
					time_due_d         = time_now_q;
					res.buffer_cleared = 1'b1;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Commit state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q  <= '0;
			time_sent_q <= '0;
			time_due_q  <= '0;
			interval_q  <= spw_pkg::INTERVAL_FLOOR_RST;
			running_q   <= 1'b0;
			pending_q   <= 1'b0;
			timed_out_q <= 1'b0;
			hold_q      <= 1'b0;
			source_q    <= '0;
		end else if (en) begin
			time_now_q  <= time_now_d;
			time_sent_q <= time_sent_d;
			time_due_q  <= time_due_d;
			interval_q  <= interval_d;
			running_q   <= running_d;
			pending_q   <= pending_d;
			timed_out_q <= timed_out_d;
			hold_q      <= hold_d;
			source_q    <= source_d;
		end
	end

endmodule

### rtl/sample_poll_watchdog.sv
// Top level of the sample poll watchdog: channel handshakes, configuration
// registers, input and result registers. Depends on spw_pkg, spw_if, spw_engine.
//
// Schedules meter readings with at most one request in flight. Every event
// item yields exactly one result item, which passes through the input register
// and then the result register. An item can be accepted every cycle while the
// result side is ready: the event sits in an input register, the scheduler state
// updates in one pass of short logic (48-bit subtracts and compares, saturating
// adds, one interval clamp), and the result waits in an output register while
// the next item is taken. Configuration writes are taken every cycle and apply at
// once; write them only while no event is in flight.
module sample_poll_watchdog (
	input  logic     clk,
	input  logic     arst_n,
	spw_evt_if.sink  evt,
	spw_res_if.source res,
	spw_cfg_if.sink  cfg
);

	logic          valid_s1, out_valid_q, adv;
	spw_pkg::evt_t item_s1;
	spw_pkg::res_t res_d, res_q;
	spw_pkg::cfg_t cfg_q;

	assign adv       = !out_valid_q || res.ready;
	assign evt.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_limit    <= spw_pkg::TIMEOUT_LIMIT_RST;
			cfg_q.interval_floor   <= spw_pkg::INTERVAL_FLOOR_RST;
			cfg_q.interval_ceiling <= spw_pkg::INTERVAL_CEILING_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				spw_pkg::CFG_TIMEOUT_LIMIT:    cfg_q.timeout_limit    <= cfg.data;
				spw_pkg::CFG_INTERVAL_FLOOR:   cfg_q.interval_floor   <= cfg.data;
				spw_pkg::CFG_INTERVAL_CEILING: cfg_q.interval_ceiling <= cfg.data;
				default: ;
			endcase
		end
	end

	// Advance valid flags of the input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (evt.ready)
				valid_s1 <= evt.valid;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	// Hold the item payloads
	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			item_s1.cmd              <= evt.cmd;
			item_s1.now_time         <= evt.now_time;
			item_s1.source_open      <= evt.source_open;
			item_s1.source_tag       <= evt.source_tag;
			item_s1.reading_value    <= evt.reading_value;
			item_s1.interval_request <= evt.interval_request;
			item_s1.hold_value       <= evt.hold_value;
		end
		if (valid_s1 && adv)
			res_q <= res_d;
	end

	spw_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (valid_s1 && adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_d)
	);

	// Drive the result channel
	assign res.valid           = out_valid_q;
	assign res.request_reading = res_q.request_reading;
	assign res.sample_valid    = res_q.sample_valid;
	assign res.sample_ok       = res_q.sample_ok;
	assign res.sample_time     = res_q.sample_time;
	assign res.sample_value    = res_q.sample_value;
	assign res.timeout_event   = res_q.timeout_event;
	assign res.failure_event   = res_q.failure_event;
	assign res.start_rejected  = res_q.start_rejected;
	assign res.buffer_cleared  = res_q.buffer_cleared;

endmodule
